>>> design/bgr_pkg.sv
// Package for the rectangle vertex-minus-edge counter.
// Shared sizes, register selects and the command type. No dependencies.
`timescale 1ns / 1ps
package bgr_pkg;
  localparam int MaxRows = 256;
  localparam int MaxCols = 256;
  localparam int RowW = $clog2(MaxRows);
  localparam int ColW = $clog2(MaxCols);
  localparam int AddrW = RowW + ColW;
  localparam int SumW = 17;
  localparam int CntW = 18;
  localparam int DimW = 9;
  localparam int QDepth = 2;

  localparam logic [0:0] RegRows = 1'b0;
  localparam logic [0:0] RegCols = 1'b1;

  typedef struct packed {
    logic           is_query;
    logic           bad;
    logic           bit_v;
    logic           h_v;
    logic           first_col;
    logic [RowW-1:0] r0;
    logic [ColW-1:0] c0;
    logic [RowW-1:0] r1;
    logic [ColW-1:0] c1;
  } cmd_t;
endpackage

>>> design/bgr_front.sv
// Front end: tracks load position, classifies items into commands.
// Uses bgr_pkg.
`timescale 1ns / 1ps
module bgr_front (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [bgr_pkg::DimW-1:0] nrows_i,
  input  logic [bgr_pkg::DimW-1:0] ncols_i,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic                    kind_i,
  input  logic                    cell_bit_i,
  input  logic [7:0]              top_row_i,
  input  logic [7:0]              left_col_i,
  input  logic [7:0]              bottom_row_i,
  input  logic [7:0]              right_col_i,
  output logic                    cmd_valid_o,
  input  logic                    cmd_full_i,
  output bgr_pkg::cmd_t           cmd_o
);
  import bgr_pkg::*;
  logic [RowW-1:0] row_q, row_d, r;
  logic [ColW-1:0] col_q, col_d, c;
  logic            ready_q, ready_d, prevc_q, prevc_d;
  logic            acc, oob, lastc, lastr;

  assign in_stall_o  = cmd_full_i;
  assign acc         = in_valid_i && !cmd_full_i;
  assign cmd_valid_o = acc;

  always_comb begin
    oob = ({1'b0, row_q} >= nrows_i) || ({1'b0, col_q} >= ncols_i);
    r = oob ? '0 : row_q;
    c = oob ? '0 : col_q;
    lastc = ({1'b0, c} + 9'd1) >= ncols_i;
    lastr = ({1'b0, r} + 9'd1) >= nrows_i;
    row_d = row_q; col_d = col_q; ready_d = oob ? 1'b0 : ready_q; prevc_d = prevc_q;
    cmd_o = '0;
    if (kind_i) begin
      cmd_o.is_query = 1'b1;
      cmd_o.bad = !ready_q || top_row_i > bottom_row_i || left_col_i > right_col_i
        || {1'b0, bottom_row_i} >= nrows_i || {1'b0, right_col_i} >= ncols_i;
      cmd_o.r0 = top_row_i; cmd_o.c0 = left_col_i;
      cmd_o.r1 = bottom_row_i; cmd_o.c1 = right_col_i;
    end else begin
      if (r == '0 && c == '0) ready_d = 1'b0;
      cmd_o.bit_v = cell_bit_i;
      cmd_o.h_v = (c != '0) && cell_bit_i && (oob ? 1'b0 : prevc_q);
      cmd_o.first_col = (c == '0);
      cmd_o.r1 = r; cmd_o.c1 = c;
      prevc_d = cell_bit_i;
      if (!lastc) begin
        col_d = c + 1'b1; row_d = r;
      end else begin
        col_d = '0;
        if (!lastr) row_d = r + 1'b1;
        else begin
          row_d = '0; ready_d = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= '0; col_q <= '0; ready_q <= 1'b0; prevc_q <= 1'b0;
    end else if (cfg_we_i) begin
      row_q <= '0; col_q <= '0; ready_q <= 1'b0; prevc_q <= 1'b0;
    end else if (acc) begin
      row_q <= row_d; col_q <= col_d; ready_q <= ready_d; prevc_q <= prevc_d;
    end
  end
endmodule

>>> design/bgr_queue.sv
// Short command queue between front and back.
// Uses bgr_pkg.
`timescale 1ns / 1ps
module bgr_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          wr_i,
  input  bgr_pkg::cmd_t wdata_i,
  output logic          full_o,
  output logic          empty_o,
  input  logic          rd_i,
  output bgr_pkg::cmd_t rdata_o
);
  import bgr_pkg::*;
  localparam int PW = $clog2(QDepth);
  cmd_t mem_q [QDepth];
  logic [PW-1:0] wp_q, rp_q;
  logic [PW:0]   cnt_q;

  assign full_o  = cnt_q == QDepth[PW:0];
  assign empty_o = cnt_q == '0;
  assign rdata_o = mem_q[rp_q];

  always_ff @(posedge clk_i) if (wr_i) mem_q[wp_q] <= wdata_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0; rp_q <= '0; cnt_q <= '0;
    end else begin
      if (wr_i) wp_q <= (wp_q == PW'(QDepth - 1)) ? '0 : wp_q + 1'b1;
      if (rd_i) rp_q <= (rp_q == PW'(QDepth - 1)) ? '0 : rp_q + 1'b1;
      cnt_q <= cnt_q + {{PW{1'b0}}, wr_i} - {{PW{1'b0}}, rd_i};
    end
  end
endmodule

>>> design/bgr_back.sv
// Back end: integral memories, load update and four-corner query sequencer.
// Uses bgr_pkg.
`timescale 1ns / 1ps
module bgr_back (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cmd_empty_i,
  output logic                    cmd_rd_o,
  input  bgr_pkg::cmd_t           cmd_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic signed [17:0]      component_count_o,
  output logic                    bad_query_o
);
  import bgr_pkg::*;
  typedef enum logic [2:0] {S_IDLE, S_RD, S_WAIT, S_ACC, S_WR, S_OUT} state_e;
  state_e st_q;
  cmd_t cm_q;
  logic [SumW-1:0] mc [MaxRows*MaxCols];
  logic [SumW-1:0] mh [MaxRows*MaxCols];
  logic [SumW-1:0] mv [MaxRows*MaxCols];
  logic            prow [MaxCols];
  logic [SumW-1:0] dc_q, dh_q, dv_q;
  logic            pb_q;
  logic [DimW-1:0] rs0_q, rs1_q, rs2_q;
  logic [1:0] k_q;
  logic signed [CntW-1:0] acc_q;
  logic [RowW-1:0] cr, hr, vr;
  logic [ColW-1:0] cc, hc, vc;
  logic rd_en, wr_en, cz_c, hz_c, vz_c, ctr_neg, rneg, cneg;
  logic [SumW-1:0] wc, wh, wv;
  logic signed [CntW-1:0] tc, th, tv, term;

  assign cmd_rd_o = (st_q == S_IDLE) && !cmd_empty_i;
  assign out_valid_o = st_q == S_OUT;

  // corner k: 0=(b,r)+ 1=(t-1,r)- 2=(b,l-1)- 3=(t-1,l-1)+
  // horiz pairs span columns l+1..r, vert pairs span rows t+1..b
  always_comb begin
    rneg = k_q[0]; cneg = k_q[1];
    if (cm_q.is_query) begin
      cr = rneg ? cm_q.r0 - 1'b1 : cm_q.r1;
      cc = cneg ? cm_q.c0 - 1'b1 : cm_q.c1;
      hr = cr;
      hc = cneg ? cm_q.c0 : cm_q.c1;
      vr = rneg ? cm_q.r0 : cm_q.r1;
      vc = cc;
    end else begin
      cr = cm_q.r1 - 1'b1; cc = cm_q.c1;
      hr = cr; hc = cc; vr = cr; vc = cc;
    end
  end

  assign rd_en = st_q == S_RD;
  assign wr_en = st_q == S_WR;
  assign wc = (cm_q.r1 != '0 ? dc_q : '0) + SumW'(rs0_q);
  assign wh = (cm_q.r1 != '0 ? dh_q : '0) + SumW'(rs1_q);
  assign wv = (cm_q.r1 != '0 ? dv_q : '0) + SumW'(rs2_q);

  always_ff @(posedge clk_i) begin
    if (wr_en) mc[{cm_q.r1, cm_q.c1}] <= wc;
    else if (rd_en) dc_q <= mc[{cr, cc}];
  end
  always_ff @(posedge clk_i) begin
    if (wr_en) mh[{cm_q.r1, cm_q.c1}] <= wh;
    else if (rd_en) dh_q <= mh[{hr, hc}];
  end
  always_ff @(posedge clk_i) begin
    if (wr_en) mv[{cm_q.r1, cm_q.c1}] <= wv;
    else if (rd_en) dv_q <= mv[{vr, vc}];
  end
  always_ff @(posedge clk_i) begin
    if (wr_en) prow[cm_q.c1] <= cm_q.bit_v;
    else if (rd_en) pb_q <= prow[cm_q.c1];
  end

  // drop corners that fall above row 0 or left of column 0
  always_comb begin
    ctr_neg = k_q[0] ^ k_q[1];
    cz_c = (rneg && cm_q.r0 == '0) || (cneg && cm_q.c0 == '0);
    hz_c = rneg && cm_q.r0 == '0;
    vz_c = cneg && cm_q.c0 == '0;
    tc = cz_c ? '0 : CntW'(dc_q);
    th = hz_c ? '0 : CntW'(dh_q);
    tv = vz_c ? '0 : CntW'(dv_q);
    term = tc - th - tv;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_IDLE; k_q <= '0; acc_q <= '0; cm_q <= '0;
      rs0_q <= '0; rs1_q <= '0; rs2_q <= '0;
      component_count_o <= '0; bad_query_o <= 1'b0;
    end else begin
      unique case (st_q)
        S_IDLE: if (!cmd_empty_i) begin
          cm_q <= cmd_i; k_q <= '0; acc_q <= '0;
          if (cmd_i.is_query) begin
            if (cmd_i.bad) begin
              component_count_o <= '0; bad_query_o <= 1'b1; st_q <= S_OUT;
            end else st_q <= S_RD;
          end else begin
            rs0_q <= (cmd_i.first_col ? '0 : rs0_q) + DimW'(cmd_i.bit_v);
            rs1_q <= (cmd_i.first_col ? '0 : rs1_q) + DimW'(cmd_i.h_v);
            rs2_q <= cmd_i.first_col ? '0 : rs2_q;
            st_q <= (cmd_i.r1 != '0) ? S_RD : S_WR;
          end
        end
        S_RD: st_q <= S_WAIT;
        S_WAIT: begin
          if (!cm_q.is_query) rs2_q <= rs2_q + DimW'(cm_q.bit_v && pb_q);
          st_q <= cm_q.is_query ? S_ACC : S_WR;
        end
        S_ACC: begin
          acc_q <= ctr_neg ? acc_q - term : acc_q + term;
          if (k_q == 2'd3) begin
            component_count_o <= ctr_neg ? acc_q - term : acc_q + term;
            bad_query_o <= 1'b0;
            st_q <= S_OUT;
          end else begin
            k_q <= k_q + 1'b1; st_q <= S_RD;
          end
        end
        S_WR: st_q <= S_IDLE;
        S_OUT: if (!out_stall_i) st_q <= S_IDLE;
        default: st_q <= S_IDLE;
      endcase
    end
  end
endmodule

>>> design/binary_grid_rect_vertex_minus_edge.sv
// Top level of the rectangle vertex-minus-edge counter.
// Uses bgr_pkg, bgr_front, bgr_queue, bgr_back.
// Back end: a query steps through read, wait and accumulate states for each of its
// four corners, then holds the output; a rejected query goes straight to the output;
// a load reads, waits and writes (only writes in row 0); a two-entry queue lets the input run ahead.
// Reset clears position, ready flag and queue; memories hold garbage until loaded.
`timescale 1ns / 1ps
module binary_grid_rect_vertex_minus_edge (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        kind_i,
  input  logic        cell_bit_i,
  input  logic [7:0]  top_row_i,
  input  logic [7:0]  left_col_i,
  input  logic [7:0]  bottom_row_i,
  input  logic [7:0]  right_col_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic signed [17:0] component_count_o,
  output logic        bad_query_o
);
  import bgr_pkg::*;
  logic [DimW-1:0] rows_q, cols_q, nr, nc;
  logic we, qfull, qempty, qrd, qwr;
  cmd_t cin, cout;

  assign pready = 1'b1;
  assign we = psel && penable && pwrite && paddr[1:0] == 2'b00 && paddr[2] <= 1'b1;
  assign prdata = paddr[2] == RegCols ? {23'd0, cols_q} : {23'd0, rows_q};
  assign nr = rows_q == '0 ? DimW'(1) : (rows_q > DimW'(MaxRows) ? DimW'(MaxRows) : rows_q);
  assign nc = cols_q == '0 ? DimW'(1) : (cols_q > DimW'(MaxCols) ? DimW'(MaxCols) : cols_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q <= DimW'(256); cols_q <= DimW'(256);
    end else if (we) begin
      if (paddr[2] == RegRows) rows_q <= pwdata[DimW-1:0];
      else cols_q <= pwdata[DimW-1:0];
    end
  end

  bgr_front u_front (
    .clk_i, .rst_ni, .cfg_we_i(we), .nrows_i(nr), .ncols_i(nc),
    .in_valid_i, .in_stall_o, .kind_i, .cell_bit_i, .top_row_i, .left_col_i,
    .bottom_row_i, .right_col_i, .cmd_valid_o(qwr), .cmd_full_i(qfull), .cmd_o(cin)
  );
  bgr_queue u_queue (
    .clk_i, .rst_ni, .wr_i(qwr), .wdata_i(cin), .full_o(qfull), .empty_o(qempty),
    .rd_i(qrd), .rdata_o(cout)
  );
  bgr_back u_back (
    .clk_i, .rst_ni, .cmd_empty_i(qempty), .cmd_rd_o(qrd), .cmd_i(cout),
    .out_valid_o, .out_stall_i, .component_count_o, .bad_query_o
  );
endmodule

>>> sim/tb.sv
// Testbench for binary_grid_rect_vertex_minus_edge: loads images, asks rectangle
// queries and checks each answer against an in-bench direct-count predictor or a fixed expected value.
// Depends on bgr_pkg and the top level only.
`timescale 1ns / 1ps
module tb;
  import bgr_pkg::*;

  localparam int ADDR_ROWS = 0;
  localparam int ADDR_COLS = 4;
  localparam int KIND_LOAD = 0;
  localparam int KIND_QUERY = 1;
  localparam int STALL_LIMIT = 20000;

  typedef struct packed {
    logic signed [CntW-1:0] count;
    logic                   bad;
  } answer_t;

  typedef enum int {OP_LOAD, OP_QUERY, OP_CFG, OP_IMAGE, OP_DRAIN} op_e;

  // a: cell bit, register address or fill percent; v: register value
  typedef struct packed {
    op_e op;
    int  a;
    int  v;
    int  t;
    int  l;
    int  b;
    int  r;
    int  has_exp;
    int  exp_count;
    int  exp_bad;
  } step_t;

  logic clk_i, rst_ni;
  logic psel, penable, pwrite;
  logic [2:0] paddr;
  logic [31:0] pwdata, prdata;
  logic pready;
  logic in_valid_i, in_stall_o, kind_i, cell_bit_i;
  logic [7:0] top_row_i, left_col_i, bottom_row_i, right_col_i;
  logic out_valid_o, out_stall_i;
  logic signed [17:0] component_count_o;
  logic bad_query_o;

  binary_grid_rect_vertex_minus_edge dut (.*);

  // predictor state
  bit img [MaxRows][MaxCols];
  bit img_ready;
  int ld_row, ld_col;
  int rows_cfg, cols_cfg;
  answer_t answers_due[$];
  int failures;
  int idle_cycles;
  bit calm;
  step_t dir_steps [27];

  initial begin
    clk_i = 0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic int clamp_dim(int v, int maxv);
    if (v == 0) return 1;
    if (v > maxv) return maxv;
    return v;
  endfunction

  function automatic void restart_load();
    ld_row = 0;
    ld_col = 0;
    img_ready = 0;
  endfunction

  function automatic void load_cell(bit b);
    int nr, nc;
    nr = clamp_dim(rows_cfg, MaxRows);
    nc = clamp_dim(cols_cfg, MaxCols);
    if (ld_row >= nr || ld_col >= nc) restart_load();
    if (ld_row == 0 && ld_col == 0) img_ready = 0;
    img[ld_row][ld_col] = b;
    if (ld_col + 1 < nc) ld_col++;
    else begin
      ld_col = 0;
      if (ld_row + 1 < nr) ld_row++;
      else begin
        ld_row = 0;
        img_ready = 1;
      end
    end
  endfunction

  function automatic answer_t count_rect(int t, int l, int b, int r);
    answer_t a;
    int n;
    a = '0;
    if (!img_ready || t > b || l > r || b >= clamp_dim(rows_cfg, MaxRows) ||
        r >= clamp_dim(cols_cfg, MaxCols)) begin
      a.bad = 1'b1;
      return a;
    end
    n = 0;
    for (int i = t; i <= b; i++)
      for (int j = l; j <= r; j++) begin
        n += int'(img[i][j]);
        if (j > l) n -= int'(img[i][j] & img[i][j-1]);
        if (i > t) n -= int'(img[i][j] & img[i-1][j]);
      end
    a.count = CntW'(n);
    return a;
  endfunction

  task automatic reg_write(int addr, int val);
    @(negedge clk_i);
    psel = 1; pwrite = 1; penable = 0; paddr = addr[2:0]; pwdata = val;
    @(negedge clk_i);
    penable = 1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel = 0; penable = 0; pwrite = 0;
    if (addr == ADDR_ROWS) rows_cfg = val & 'h1ff;
    else cols_cfg = val & 'h1ff;
    restart_load();
  endtask

  task automatic send(int kind, bit b, int t, int l, int bo, int r, bit use_exp,
                      answer_t fixed_a);
    while (!calm && $urandom_range(99) < 8) @(negedge clk_i);
    in_valid_i = 1;
    kind_i = kind[0]; cell_bit_i = b;
    top_row_i = t[7:0]; left_col_i = l[7:0]; bottom_row_i = bo[7:0]; right_col_i = r[7:0];
    do @(posedge clk_i); while (in_stall_o);
    if (kind == KIND_QUERY) begin
      if (use_exp) answers_due.push_back(fixed_a);
      else answers_due.push_back(count_rect(t, l, bo, r));
    end else load_cell(b);
    @(negedge clk_i);
    in_valid_i = 0;
  endtask

  task automatic drain();
    while (answers_due.size() != 0) @(negedge clk_i);
    repeat (30) @(negedge clk_i);
  endtask

  task automatic load_image(int pct);
    int n;
    n = clamp_dim(rows_cfg, MaxRows) * clamp_dim(cols_cfg, MaxCols);
    for (int k = 0; k < n; k++)
      send(KIND_LOAD, $urandom_range(99) < pct, 0, 0, 0, 0, 1'b0, '0);
  endtask

  task automatic rand_query();
    int nr, nc, t, l, bo, r;
    nr = clamp_dim(rows_cfg, MaxRows);
    nc = clamp_dim(cols_cfg, MaxCols);
    if ($urandom_range(9) == 0) begin
      send(KIND_QUERY, 1'($urandom_range(1)), $urandom_range(255), $urandom_range(255),
           $urandom_range(255), $urandom_range(255), 1'b0, '0);
      return;
    end
    t = $urandom_range(nr - 1); bo = $urandom_range(nr - 1, t);
    l = $urandom_range(nc - 1); r = $urandom_range(nc - 1, l);
    send(KIND_QUERY, 1'($urandom_range(1)), t, l, bo, r, 1'b0, '0);
  endtask

  always @(posedge clk_i) begin
    answer_t exp_a;
    if (out_valid_o && !out_stall_i) begin
      if (answers_due.size() == 0) begin
        $display("%0t: unexpected answer count=%0d bad=%0b", $time,
                 component_count_o, bad_query_o);
        failures++;
      end else begin
        exp_a = answers_due.pop_front();
        if (exp_a.count !== component_count_o || exp_a.bad !== bad_query_o) begin
          $display("%0t: expected count=%0d bad=%0b, got count=%0d bad=%0b", $time,
                   exp_a.count, exp_a.bad, component_count_o, bad_query_o);
          failures++;
        end
      end
    end
  end

  always @(negedge clk_i)
    out_stall_i <= !calm && $urandom_range(99) < 8;

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || psel)
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > STALL_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    int dims [4][2];
    answer_t fixed_a;
    psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
    in_valid_i = 0; kind_i = 0; cell_bit_i = 0;
    top_row_i = 0; left_col_i = 0; bottom_row_i = 0; right_col_i = 0;
    failures = 0; idle_cycles = 0; calm = 0;
    rows_cfg = 256; cols_cfg = 256; restart_load();
    rst_ni = 0;
    repeat (2) @(negedge clk_i);
    rst_ni = 1;

    // op, a, v, t, l, b, r, has_exp, exp_count, exp_bad
    dir_steps = '{
      '{OP_QUERY, 0, 0, 0, 0, 0, 0, 1, 0, 1},
      '{OP_QUERY, 1, 0, 255, 255, 255, 255, 1, 0, 1},
      '{OP_DRAIN, 0, 0, 0, 0, 0, 0, 0, 0, 0},
      '{OP_CFG, ADDR_ROWS, 0, 0, 0, 0, 0, 0, 0, 0},
      '{OP_CFG, ADDR_COLS, 0, 0, 0, 0, 0, 0, 0, 0},
      '{OP_LOAD, 1, 0, 0, 0, 0, 0, 0, 0, 0},
      '{OP_QUERY, 0, 0, 0, 0, 0, 0, 1, 1, 0},
      '{OP_QUERY, 0, 0, 0, 0, 0, 1, 1, 0, 1},
      '{OP_DRAIN, 0, 0, 0, 0, 0, 0, 0, 0, 0},
      '{OP_CFG, ADDR_ROWS, 3, 0, 0, 0, 0, 0, 0, 0},
      '{OP_CFG, ADDR_COLS, 4, 0, 0, 0, 0, 0, 0, 0},
      '{OP_IMAGE, 100, 0, 0, 0, 0, 0, 0, 0, 0},
      '{OP_QUERY, 0, 0, 0, 0, 2, 3, 0, 0, 0},
      '{OP_QUERY, 0, 0, 1, 1, 1, 1, 1, 1, 0},
      '{OP_QUERY, 0, 0, 2, 0, 1, 0, 1, 0, 1},
      '{OP_QUERY, 0, 0, 0, 3, 0, 2, 1, 0, 1},
      '{OP_QUERY, 0, 0, 0, 0, 3, 0, 1, 0, 1},
      '{OP_QUERY, 0, 0, 0, 0, 0, 4, 1, 0, 1},
      '{OP_LOAD, 0, 0, 0, 0, 0, 0, 0, 0, 0},
      '{OP_QUERY, 0, 0, 0, 0, 0, 0, 1, 0, 1},
      '{OP_DRAIN, 0, 0, 0, 0, 0, 0, 0, 0, 0},
      '{OP_CFG, ADDR_ROWS, 'h1ff, 0, 0, 0, 0, 0, 0, 0},
      '{OP_CFG, ADDR_COLS, 1, 0, 0, 0, 0, 0, 0, 0},
      '{OP_IMAGE, 50, 0, 0, 0, 0, 0, 0, 0, 0},
      '{OP_QUERY, 0, 0, 0, 0, 255, 0, 0, 0, 0},
      '{OP_QUERY, 0, 0, 255, 0, 255, 0, 0, 0, 0},
      '{OP_DRAIN, 0, 0, 0, 0, 0, 0, 0, 0, 0}
    };

    foreach (dir_steps[s]) begin
      unique case (dir_steps[s].op)
        OP_LOAD: send(KIND_LOAD, dir_steps[s].a[0], 0, 0, 0, 0, 1'b0, '0);
        OP_QUERY: begin
          fixed_a.count = CntW'(dir_steps[s].exp_count);
          fixed_a.bad = dir_steps[s].exp_bad[0];
          send(KIND_QUERY, dir_steps[s].a[0], dir_steps[s].t, dir_steps[s].l,
               dir_steps[s].b, dir_steps[s].r, dir_steps[s].has_exp != 0, fixed_a);
        end
        OP_CFG: reg_write(dir_steps[s].a, dir_steps[s].v);
        OP_IMAGE: load_image(dir_steps[s].a);
        OP_DRAIN: drain();
      endcase
    end

    dims = '{'{5, 6}, '{1, 40}, '{8, 3}, '{2, 2}};
    for (int p = 0; p < 4; p++) begin
      reg_write(ADDR_ROWS, dims[p][0]);
      reg_write(ADDR_COLS, dims[p][1]);
      calm = (p == 2);
      for (int img_n = 0; img_n < 2; img_n++) begin
        load_image($urandom_range(100));
        repeat (30) rand_query();
        if (img_n == 0) drain();
      end
      drain();
    end
    calm = 0;
    drain();
    if (failures == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end
endmodule

>>> binary_grid_rect_vertex_minus_edge.f
design/bgr_pkg.sv
design/bgr_front.sv
design/bgr_queue.sv
design/bgr_back.sv
design/binary_grid_rect_vertex_minus_edge.sv
sim/tb.sv
